// ===== sv/setq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_pkg
// shared types and constants of the sorted event timer queue
// ----------------------------------------------------------------------------
package setq_pkg;

  localparam int unsigned MAX_EVENTS_DEF = 32;
  localparam int unsigned ID_W = 5;
  localparam int unsigned CFG_W = 31;
  localparam logic [CFG_W-1:0] CLOCKS_PER_MS_RST = 31'd1000;
  localparam logic [CFG_W-1:0] IDLE_SLICE_RST = 31'd65536;
  localparam logic [31:0] NOT_PENDING = 32'hFFFF_FFFF;

  localparam logic [2:0] K_RUN = 3'd0;
  localparam logic [2:0] K_PROGRESS = 3'd1;
  localparam logic [2:0] K_SET = 3'd2;
  localparam logic [2:0] K_REMOVE = 3'd3;
  localparam logic [2:0] K_QUERY = 3'd4;
  localparam logic [2:0] K_EXIT = 3'd5;
  localparam logic [2:0] K_LOAD = 3'd6;
  localparam logic [2:0] K_UNUSED = 3'd7;

  localparam logic CFG_CPMS = 1'b0;
  localparam logic CFG_IDLE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture the input item
    logic scan_rst;  // clear scan index
    logic scan_step; // one list entry
    logic prog_fin;  // progress: commit slice
    logic mul_fin;   // set: product ready
    logic set_drop;  // set: drop slot from list
    logic ins_step;  // set: insertion walk entry
    logic ins_fin;   // set: place slot
    logic rem_fin;   // remove: shift out
    logic simple;    // run, exit, load, unused
    logic emit;      // load output register
    logic emit_last;
    logic emit_fire; // emitted result carries a fired id
  } setq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic fire_any;   // progress step fired at least one notifying event
    logic fire_last;  // fired id about to be emitted is the final one
    logic ins_done;
  } setq_sts_t;

endpackage

// ===== sv/setq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_dp
// event store, ordered list and slice arithmetic
// ----------------------------------------------------------------------------
module setq_dp #(
  parameter int unsigned MAX_EVENTS = setq_pkg::MAX_EVENTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_index,
  input  logic [30:0] cfg_wr_data,
  input  logic [2:0] in_kind,
  input  logic [4:0] in_event_id,
  input  logic signed [31:0] in_amount,
  input  logic in_absolute,
  input  logic in_by_ms,
  input  logic in_notify,
  input  setq_pkg::setq_cmd_t cmd,
  output setq_pkg::setq_sts_t sts,
  output logic [2:0] kind_o,
  output logic id_ovf_o,
  output logic out_fired_valid,
  output logic [4:0] out_fired_id,
  output logic out_last,
  output logic signed [31:0] out_slice_length,
  output logic signed [31:0] out_cycles_left,
  output logic out_is_working,
  output logic signed [31:0] out_time_left,
  output logic [31:0] out_total_clock
);
  import setq_pkg::*;

  localparam int unsigned IW = $clog2(MAX_EVENTS);
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

  logic [31:0] due_r [MAX_EVENTS];
  logic [MAX_EVENTS-1:0] ntf_r;
  logic [IW-1:0] ord_r [MAX_EVENTS];
  logic [IW-1:0] fq_r [MAX_EVENTS];
  logic [CW-1:0] cnt_r, kept_r, idx_r, nf_r, rd_r;
  logic pos_hit_r, found_r;
  logic [CW-1:0] fpos_r;
  logic [31:0] base_r, rem_r, tot_r, next_r, prod_r;
  logic [30:0] cpms_r, idle_r;
  logic [2:0] kind_r;
  logic [4:0] id_r;
  logic [31:0] amt_r;
  logic abs_r, ms_r, ntf_in_r;
  logic ovf_id;

  logic [IW-1:0] cur_e, id_e;
  logic [31:0] cur_due, dec_due, now_w, new_due;
  logic cur_pos, cur_fire;

  assign kind_o = kind_r;
  assign id_ovf_o = ovf_id;
  assign ovf_id = ({27'd0, id_r} >= 32'(MAX_EVENTS));
  assign id_e = IW'(id_r);
  assign cur_e = ord_r[idx_r[IW-1:0]];
  assign cur_due = due_r[cur_e];
  assign dec_due = cur_due - base_r;
  assign cur_pos = (dec_due != 32'd0) && !dec_due[31];
  assign cur_fire = !cur_pos && ntf_r[cur_e];
  assign now_w = base_r - rem_r;
  assign new_due = abs_r ? prod_r + now_w : due_r[id_e] + prod_r;

  assign sts.scan_done = (idx_r >= cnt_r);
  assign sts.fire_any = (nf_r != '0);
  assign sts.fire_last = (rd_r + 1'b1 == nf_r);
  assign sts.ins_done = (idx_r >= cnt_r) || pos_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      base_r <= '0;
      rem_r <= '0;
      tot_r <= '0;
      ntf_r <= '0;
      cpms_r <= CLOCKS_PER_MS_RST;
      idle_r <= IDLE_SLICE_RST;
      for (int i = 0; i < int'(MAX_EVENTS); i++) begin
        due_r[i] <= '0;
        ord_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_CPMS) cpms_r <= cfg_wr_data;
        else idle_r <= cfg_wr_data;
      end
      if (cmd.latch) begin
        kind_r <= in_kind;
        id_r <= in_event_id;
        amt_r <= in_amount;
        abs_r <= in_absolute;
        ms_r <= in_by_ms;
        ntf_in_r <= in_notify;
        next_r <= {1'b0, idle_r};
        kept_r <= '0;
        nf_r <= '0;
      end
      if (cmd.scan_rst) begin
        idx_r <= '0;
        found_r <= 1'b0;
        pos_hit_r <= 1'b0;
      end
      // scan: progress compacts and queues fired ids, others search id position
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        if (kind_r == K_PROGRESS) begin
          due_r[cur_e] <= dec_due;
          if (cur_fire) begin
            fq_r[nf_r[IW-1:0]] <= cur_e;
            nf_r <= nf_r + 1'b1;
          end
          if (cur_pos) begin
            ord_r[kept_r[IW-1:0]] <= cur_e;
            kept_r <= kept_r + 1'b1;
            if (!(($signed(next_r)) < $signed(dec_due))) next_r <= dec_due;
          end
        end else if (!found_r && cur_e == id_e) begin
          found_r <= 1'b1;
          fpos_r <= idx_r;
        end
      end
      if (cmd.prog_fin) begin
        tot_r <= tot_r + base_r;
        cnt_r <= kept_r;
        base_r <= next_r;
        rem_r <= rem_r + next_r;
        rd_r <= '0;
      end
      // fired ids leave in list order
      if (cmd.emit && cmd.emit_fire) rd_r <= rd_r + 1'b1;
      if (cmd.mul_fin) begin
        prod_r <= ms_r ? {1'b0, cpms_r} * amt_r : amt_r;
      end
      if (cmd.set_drop) begin
        ntf_r[id_e] <= ntf_in_r;
        due_r[id_e] <= new_due;
        if (found_r) begin
          for (int i = 0; i < int'(MAX_EVENTS) - 1; i++)
            if (CW'(i) >= fpos_r) ord_r[i] <= ord_r[i+1];
          cnt_r <= cnt_r - 1'b1;
        end
        idx_r <= '0;
        pos_hit_r <= 1'b0;
      end
      if (cmd.ins_step) begin
        if ($signed(due_r[id_e]) < $signed(cur_due)) pos_hit_r <= 1'b1;
        else idx_r <= idx_r + 1'b1;
      end
      if (cmd.ins_fin) begin
        for (int i = 1; i < int'(MAX_EVENTS); i++)
          if (CW'(i) > idx_r && CW'(i) <= cnt_r) ord_r[i] <= ord_r[i-1];
        ord_r[idx_r[IW-1:0]] <= id_e;
        cnt_r <= cnt_r + 1'b1;
        if (idx_r == '0) begin
          rem_r <= rem_r - (base_r - due_r[id_e]);
          base_r <= due_r[id_e];
        end
      end
      if (cmd.rem_fin && found_r) begin
        for (int i = 0; i < int'(MAX_EVENTS) - 1; i++)
          if (CW'(i) >= fpos_r) ord_r[i] <= ord_r[i+1];
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.simple) begin
        unique case (kind_r)
          K_RUN: rem_r <= rem_r - amt_r;
          K_EXIT: if (rem_r != 32'd0 && !rem_r[31]) begin
            base_r <= base_r - rem_r;
            rem_r <= '0;
          end
          K_LOAD: begin
            base_r <= (cnt_r != '0) ? due_r[ord_r[0]] : {1'b0, idle_r};
            rem_r <= (cnt_r != '0) ? due_r[ord_r[0]] : {1'b0, idle_r};
          end
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fired_valid <= cmd.emit_fire;
      out_fired_id <= cmd.emit_fire ? 5'(fq_r[rd_r[IW-1:0]]) : 5'd0;
      out_last <= cmd.emit_last;
      out_slice_length <= base_r;
      out_cycles_left <= rem_r;
      out_total_clock <= tot_r;
      out_is_working <= (kind_r == K_QUERY) && found_r && !ovf_id;
      out_time_left <= (kind_r != K_QUERY) ? 32'd0 :
                       (found_r && !ovf_id) ? due_r[id_e] - now_w : NOT_PENDING;
    end
  end
endmodule

// ===== sv/setq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setq_ctrl
// sequencer for one item at a time
// ----------------------------------------------------------------------------
module setq_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic [2:0] kind,
  input  logic id_ovf,
  input  setq_pkg::setq_sts_t sts,
  output setq_pkg::setq_cmd_t cmd
);
  import setq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_DEC  = 9'b000000010, S_SCAN = 9'b000000100,
    S_FEMT = 9'b000001000, S_PFIN = 9'b000010000, S_MUL  = 9'b000100000,
    S_DROP = 9'b001000000, S_INS  = 9'b010000000, S_OUT  = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;
  logic ov_r, ov_nxt;

  assign out_valid = ov_r;
  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    ov_nxt = ov_r && out_stall;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        cmd.latch = 1'b1;
        cmd.scan_rst = 1'b1;
        st_nxt = S_DEC;
      end
      S_DEC: begin
        if (kind == K_RUN || kind == K_EXIT || kind == K_LOAD || kind == K_UNUSED) begin
          cmd.simple = 1'b1;
          st_nxt = S_OUT;
        end else if (kind == K_SET && id_ovf) st_nxt = S_OUT;
        else if (kind == K_REMOVE && id_ovf) st_nxt = S_OUT;
        else st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (kind == K_PROGRESS) st_nxt = S_PFIN;
          else if (kind == K_SET) st_nxt = S_MUL;
          else begin
            if (kind == K_REMOVE) cmd.rem_fin = 1'b1;
            st_nxt = S_OUT;
          end
        end else cmd.scan_step = 1'b1;
      end
      S_FEMT: if (!ov_nxt) begin
        // one fired id per transfer, last on the final one
        cmd.emit = 1'b1;
        cmd.emit_fire = 1'b1;
        cmd.emit_last = sts.fire_last;
        ov_nxt = 1'b1;
        if (sts.fire_last) st_nxt = S_IDLE;
      end
      S_PFIN: begin
        cmd.prog_fin = 1'b1;
        st_nxt = sts.fire_any ? S_FEMT : S_OUT;
      end
      S_MUL: begin
        cmd.mul_fin = 1'b1;
        st_nxt = S_DROP;
      end
      S_DROP: begin
        cmd.set_drop = 1'b1;
        st_nxt = S_INS;
      end
      S_INS: begin
        if (sts.ins_done) begin
          cmd.ins_fin = 1'b1;
          st_nxt = S_OUT;
        end else cmd.ins_step = 1'b1;
      end
      S_OUT: if (!ov_nxt) begin
        cmd.emit = 1'b1;
        cmd.emit_last = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

// ===== sv/sorted_event_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_event_timer_queue_unit
// timer event scheduler over a due-time ordered list
// ----------------------------------------------------------------------------
// latency from accept to result load: run/exit/load/unused only decode;
//   query, remove and set walk the list, set again to insert; progress
//   walks, commits, then one fired-id transfer a cycle while not stalled
// throughput: one item at a time; the list walk, one entry a cycle, sets it
// reset: synchronous active-low rst_n clears the list, slices and totals and
//   loads the register defaults
module sorted_event_timer_queue_unit #(
  parameter int unsigned MAX_EVENTS = setq_pkg::MAX_EVENTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_index,
  input  logic [30:0] cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] in_kind,
  input  logic [4:0] in_event_id,
  input  logic signed [31:0] in_amount,
  input  logic in_absolute,
  input  logic in_by_ms,
  input  logic in_notify,
  output logic out_valid,
  input  logic out_stall,
  output logic out_fired_valid,
  output logic [4:0] out_fired_id,
  output logic out_last,
  output logic signed [31:0] out_slice_length,
  output logic signed [31:0] out_cycles_left,
  output logic out_is_working,
  output logic signed [31:0] out_time_left,
  output logic [31:0] out_total_clock
);
  import setq_pkg::*;

  setq_cmd_t cmd;
  setq_sts_t sts;
  logic [2:0] kind;
  logic id_ovf;

  // sequencer: one transfer in, then walk the list where the kind needs it
  setq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .kind, .id_ovf, .sts, .cmd
  );

  // store, list and slice registers; also flags an out-of-range id
  setq_dp #(.MAX_EVENTS(MAX_EVENTS)) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .in_kind, .in_event_id, .in_amount, .in_absolute, .in_by_ms, .in_notify,
    .cmd, .sts, .kind_o(kind), .id_ovf_o(id_ovf),
    .out_fired_valid, .out_fired_id, .out_last, .out_slice_length,
    .out_cycles_left, .out_is_working, .out_time_left, .out_total_clock
  );
endmodule
